FILE: rtl/vfit_pkg.sv
package vfit_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_W      = 32;
    localparam int WORDS       = 8;
    localparam int VTX_W       = WORD_W * WORDS;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Result field widths and stream packing
    localparam int OUT_IDX_W   = 10;
    localparam int OUT_FIELD_W = OUT_IDX_W + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Request kinds carried on tuser
    typedef enum logic {
        OP_FIND  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VTX_W-1:0] vtx;
    } req_t;

    typedef struct packed {
        logic                 table_full;
        logic                 was_found;
        logic [OUT_IDX_W-1:0] vertex_index;
    } res_t;

endpackage

FILE: rtl/vertex_find_or_insert_table.sv
// Vertex find-or-insert table.
// Slave stream: one request per beat. s_tuser is the op (0 find or insert,
// 1 clear); s_tdata carries eight 32-bit words, pos_x in the lowest bits.
// Master stream: one result per request, m_tdata = vertex_index, was_found,
// table_full from the lowest bit up.
// A find walks the stored vertices newest to oldest, one table read per
// cycle through a single-port memory of up to 1024 entries. The next
// request is taken once the previous result has moved to the output
// register.
// A miss appends the vertex; a miss on a full table stores nothing and
// reports table_full with index 0.
// Reset empties the table at once (the stored count goes to zero; the
// memory needs no clearing pass). A stalled m_tready holds the result in
// the output register and the next result in the core; requests then
// stall on s_tready.
module vertex_find_or_insert_table
    import vfit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
    input  logic [VTX_W-1:0]       s_tdata,
    // op
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // vertex_index[9:0], was_found, table_full, zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    req_t req;
    res_t core_res;
    logic core_res_valid;
    logic core_res_ready;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    // Unpack the request
    assign req.op  = op_t'(s_tuser);
    assign req.vtx = s_tdata;

    vfit_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    // Output register: load when empty or being drained
    assign core_res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (core_res_ready)
        begin
            out_valid_next = core_res_valid;
            if (core_res_valid)
            begin
                out_res_next = core_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg};

endmodule

FILE: rtl/vfit_ram.sv
module vfit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    addr,
    input  logic [WIDTH-1:0]                                wdata,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

FILE: rtl/vfit_core.sv
module vfit_core
    import vfit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [VTX_W-1:0]   vtx_reg, vtx_next;
    res_t               res_reg, res_next;

    logic               ram_en;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [VTX_W-1:0]   ram_rdata;
    logic               hit;
    logic               full;
    logic [CNT_W-1:0]   ptr_dec;

    // Reads and the single append write never overlap: the append happens
    // only once the scan has ended, so no forwarding is needed.
    vfit_ram #(
        .WIDTH (VTX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (vtx_reg),
        .rdata (ram_rdata)
    );

    assign hit     = pend_reg && (ram_rdata == vtx_reg);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ptr_dec = ptr_reg - CNT_W'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    // Scan newest to oldest, one read a cycle, compare in the next cycle
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pend_next   = 1'b0;
        rd_idx_next = rd_idx_reg;
        vtx_next    = vtx_reg;
        res_next    = res_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = ptr_dec[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    vtx_next = req.vtx;
                    if (req.op == OP_CLEAR)
                    begin
                        count_next = '0;
                        res_next   = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ptr_next   = count_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.vertex_index = OUT_IDX_W'(rd_idx_reg);
                    res_next.was_found    = 1'b1;
                    res_next.table_full   = 1'b0;
                    state_next            = ST_RESP;
                end
                else if (ptr_reg != '0)
                begin
                    ram_en      = 1'b1;
                    ptr_next    = ptr_dec;
                    pend_next   = 1'b1;
                    rd_idx_next = ptr_dec[IDX_W-1:0];
                end
                else if (full)
                begin
                    res_next.vertex_index = '0;
                    res_next.was_found    = 1'b0;
                    res_next.table_full   = 1'b1;
                    state_next            = ST_RESP;
                end
                else
                begin
                    // Append the new vertex at the end of the table
                    ram_en                = 1'b1;
                    ram_we                = 1'b1;
                    ram_addr              = count_reg[IDX_W-1:0];
                    count_next            = count_reg + CNT_W'(1);
                    res_next.vertex_index = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                    res_next.was_found    = 1'b0;
                    res_next.table_full   = 1'b0;
                    state_next            = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        rd_idx_reg <= rd_idx_next;
        vtx_reg    <= vtx_next;
        res_reg    <= res_next;
    end

endmodule
